>>> hdl/min_priority_queue_defines.svh
// Assertion macros for the priority queue.
`ifndef MIN_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define MPQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check a consequence in the cycle after a trigger.
`define MPQ_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

>>> hdl/mpq_pkg.sv
`default_nettype none
package mpq_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int FILL_W     = 5;

  localparam logic DO_PUSH = 1'b0;
  localparam logic DO_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                  push;
    logic                  pop;
    logic [VALUE_BITS-1:0] value;
  } cell_cmd_t;

  typedef struct packed {
    logic                  valid;
    logic                  keep;
    logic [VALUE_BITS-1:0] value;
  } cell_link_t;

endpackage
`default_nettype wire

>>> hdl/mpq_cell.sv
`default_nettype none
module mpq_cell (
  input  logic               clk,
  input  logic               rst,
  input  mpq_pkg::cell_cmd_t  cmd,
  input  mpq_pkg::cell_link_t from_prev,
  input  mpq_pkg::cell_link_t from_next,
  output mpq_pkg::cell_link_t link
);
  import mpq_pkg::*;

  logic                  valid;
  logic                  valid_next;
  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] value_next;
  logic                  keep;

  assign keep = valid && (value <= cmd.value);

  always_comb begin
    valid_next = valid;
    value_next = value;
    if (cmd.push) begin
      valid_next = valid | from_prev.valid;
      if (!keep) begin
        value_next = from_prev.keep ? cmd.value : from_prev.value;
      end
    end else if (cmd.pop) begin
      valid_next = from_next.valid;
      value_next = from_next.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    value <= value_next;
  end

  assign link.valid = valid;
  assign link.keep  = keep;
  assign link.value = value;

endmodule
`default_nettype wire

>>> hdl/min_priority_queue.sv
// Bounded minimum-priority queue built as a sorted chain of cells.
// Command channel: an item (action, value) is taken at a rising edge with
// start high and busy low. action 0 pushes value, action 1 pops the smallest
// stored value. busy stays low, so a new item may be issued every cycle.
// Result channel: done is high for one cycle, the cycle after the item was
// taken, with popped_value, status and fill_count. Throughput is one item
// per cycle: each cell compares its entry against the broadcast value and
// either holds it, takes the new value, or takes its neighbor's entry, all
// in the same edge.
// status: 0 ok, 1 pop while empty, 2 push while full. A refused item leaves
// the queue unchanged and returns popped_value zero. Equal values leave in
// arrival order.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (rst, synchronous) empties the queue and clears done; entry
// contents are not cleared, only their valid bits.
`default_nettype none
`include "min_priority_queue_defines.svh"
module min_priority_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           action,
  input  logic [mpq_pkg::VALUE_BITS-1:0] value,
  output logic                           done,
  output logic [mpq_pkg::VALUE_BITS-1:0] popped_value,
  output logic [1:0]                     status,
  output logic [mpq_pkg::FILL_W-1:0]     fill_count
);
  import mpq_pkg::*;

  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  refuse_push;
  cell_cmd_t             cmd;
  cell_link_t            links [CAPACITY];
  cell_link_t            head_link;
  cell_link_t            tail_link;
  logic [CAPACITY-1:0]   valid_bits;
  logic [CAPACITY-1:0]   valid_step;
  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    count_next;
  status_t               status_next;
  status_t               status_reg;
  logic [VALUE_BITS-1:0] popped_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == COUNT_W'(CAPACITY));
  assign empty  = (count == '0);

  assign refuse_push = accept && (action == DO_PUSH) && full;

  assign cmd.push  = accept && (action == DO_PUSH) && !full;
  assign cmd.pop   = accept && (action == DO_POP) && !empty;
  assign cmd.value = value;

  assign head_link.valid = 1'b1;
  assign head_link.keep  = 1'b1;
  assign head_link.value = '0;
  assign tail_link.valid = 1'b0;
  assign tail_link.keep  = 1'b0;
  assign tail_link.value = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t prev_link;
    cell_link_t next_link;
    if (i == 0) begin : g_head
      assign prev_link = head_link;
    end else begin : g_mid
      assign prev_link = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_link = tail_link;
    end else begin : g_body
      assign next_link = links[i+1];
    end
    mpq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .from_prev (prev_link),
      .from_next (next_link),
      .link      (links[i])
    );
    assign valid_bits[i] = links[i].valid;
  end

  assign valid_step = valid_bits + 1'b1;

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    popped_next = '0;
    if (accept) begin
      if (action == DO_POP) begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next  = count - 1'b1;
          popped_next = links[0].value;
        end
      end else begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
    status_reg   <= status_next;
    popped_value <= popped_next;
    fill_count   <= FILL_W'(count_next);
  end

  assign status = status_reg;

  `MPQ_ASSERT_NEXT(a_done_follows_accept, accept, done, "result strobe missing")
  `MPQ_ASSERT_ALWAYS(a_count_matches_cells, $countones(valid_bits) == int'(count), "count off")
  `MPQ_ASSERT_ALWAYS(a_cells_packed, (valid_bits & valid_step) == '0, "cells not packed")
  `MPQ_ASSERT_NEXT(a_full_refused, refuse_push, status == ST_FULL, "full push not flagged")

endmodule
`default_nettype wire

>>> verif/min_priority_queue_checker.sv
`default_nettype none
module min_priority_queue_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic                           action,
  input  logic [mpq_pkg::VALUE_BITS-1:0] value,
  input  logic                           done,
  input  logic [mpq_pkg::VALUE_BITS-1:0] popped_value,
  input  logic [1:0]                     status,
  input  logic [mpq_pkg::FILL_W-1:0]     fill_count,
  output int                             mismatch_count,
  output int                             outcomes_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mpq_pkg::*;

  typedef struct {
    logic [VALUE_BITS-1:0] popped;
    status_t               status;
    logic [FILL_W-1:0]     fill;
  } outcome_t;

  logic [VALUE_BITS-1:0] sorted_vals[$];
  outcome_t              outcomes_due[$];
  int                    mismatches = 0;

  assign mismatch_count = mismatches;

  function automatic outcome_t apply_transaction(logic act, logic [VALUE_BITS-1:0] val);
    outcome_t res;
    int       pos;
    res.popped = '0;
    res.status = ST_OK;
    if (act == DO_PUSH) begin
      if (sorted_vals.size() >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        // keep equal values ahead of the new one
        pos = sorted_vals.size();
        while (pos > 0 && sorted_vals[pos-1] > val) pos--;
        sorted_vals.insert(pos, val);
      end
    end else if (sorted_vals.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.popped = sorted_vals[0];
      sorted_vals.delete(0);
    end
    res.fill = FILL_W'(sorted_vals.size());
    return res;
  endfunction

  always @(posedge clk) begin : watch
    outcome_t want;
    if (rst) begin
      sorted_vals.delete();
      outcomes_due.delete();
    end else begin
      if (start && !busy)
        outcomes_due.insert(outcomes_due.size(), apply_transaction(action, value));
      if (done) begin
        if (outcomes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result popped_value %h status %0d fill_count %0d",
                     $realtime, popped_value, status, fill_count);
        end else begin
          want = outcomes_due[0];
          outcomes_due.delete(0);
          if (popped_value !== want.popped || status !== want.status ||
              fill_count !== want.fill) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch expected %h/%0d/%0d actual %h/%0d/%0d",
                       $realtime, want.popped, want.status, want.fill,
                       popped_value, status, fill_count);
          end
        end
      end
    end
    outcomes_pending <= outcomes_due.size();
  end

endmodule
`default_nettype wire

>>> verif/min_priority_queue_test.sv
`default_nettype none
module min_priority_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mpq_pkg::*;

  localparam int   ITEM_TARGET = 1650;

  localparam logic [VALUE_BITS-1:0] FIRST_FILL [16] = '{
    32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0005, 32'h0000_0005,
    32'h0000_0005, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA,
    32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0000,
    32'h0000_0005, 32'h1234_5678, 32'h0000_0002, 32'hFFFF_FFFF
  };

  logic                  clk    = 1'b0;
  logic                  rst    = 1'b1;
  logic                  start  = 1'b0;
  logic                  action = DO_PUSH;
  logic [VALUE_BITS-1:0] value  = '0;
  logic                  busy;
  logic                  done;
  logic [VALUE_BITS-1:0] popped_value;
  logic [1:0]            status;
  logic [FILL_W-1:0]     fill_count;
  int                    mismatch_count;
  int                    outcomes_pending;
  int                    gap_cap = 18;

  min_priority_queue i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .value        (value),
    .done         (done),
    .popped_value (popped_value),
    .status       (status),
    .fill_count   (fill_count)
  );

  min_priority_queue_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .action           (action),
    .value            (value),
    .done             (done),
    .popped_value     (popped_value),
    .status           (status),
    .fill_count       (fill_count),
    .mismatch_count   (mismatch_count),
    .outcomes_pending (outcomes_pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic issue(logic act, logic [VALUE_BITS-1:0] val);
    int gap;
    gap = $urandom_range(0, gap_cap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    action <= act;
    value  <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return VALUE_BITS'($urandom_range(0, 7));
      1:       return '1 - VALUE_BITS'($urandom_range(0, 7));
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int seg_len;
    int push_pct;
    sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    issue(DO_POP, '1);
    foreach (FIRST_FILL[i]) issue(DO_PUSH, FIRST_FILL[i]);
    issue(DO_PUSH, 32'h0000_0003);
    repeat (5) issue(DO_POP, VALUE_BITS'($urandom));

    while (sent < ITEM_TARGET) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0:       push_pct = 15;
        1:       push_pct = 50;
        default: push_pct = 85;
      endcase
      gap_cap = ($urandom_range(0, 2) == 0) ? 0 : 18;
      repeat (seg_len) begin
        issue(($urandom_range(0, 99) < push_pct) ? DO_PUSH : DO_POP, pick_value());
        sent++;
      end
    end
    start <= 1'b0;

    do @(posedge clk); while (outcomes_pending != 0);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && outcomes_pending == 0)
      $display("PASS min_priority_queue");
    else
      $display("FAIL min_priority_queue");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL min_priority_queue");
    $finish;
  end

endmodule
`default_nettype wire
